@@ rtl/core/tdb_pkg.sv @@
// Shared types and constants for the TIFF directory builder.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package tdb_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_TRAILER = 2'd2;
   localparam logic [1:0] KIND_FULL    = 2'd3;

   // Input commands
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   localparam logic [31:0] ENTRY_BYTES = 32'd12;
   localparam logic [31:0] COUNT_BYTES = 32'd2;
   localparam logic [31:0] LINK_BYTES  = 32'd4;

   typedef struct packed {
      logic        cmd;
      logic [15:0] tag_id;
      logic [3:0]  tag_type;
      logic [27:0] value_count;
      logic [31:0] inline_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [5:0]  entry_total;
      logic [15:0] out_tag_id;
      logic [3:0]  out_tag_type;
      logic [27:0] out_count;
      logic [31:0] value_field;
      logic [31:0] directory_size;
      logic        last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;
      logic add;
      logic header;
      logic scan;
      logic pick;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_is_emit;
      logic scan_last;
      logic best_found;
   } dp_status_type;

   // Stored size: count times type size, rounded up to even, modulo 2^32
   function automatic logic [31:0] stored_size(input logic [27:0] count,
                                               input logic [3:0] ftype);
      logic [31:0] prod;
      begin
         case (ftype)
            4'd1, 4'd2, 4'd6, 4'd7: prod = {4'b0, count};
            4'd3, 4'd8:             prod = {3'b0, count, 1'b0};
            4'd4, 4'd9, 4'd11:      prod = {2'b0, count, 2'b0};
            4'd5, 4'd10, 4'd12:     prod = {1'b0, count, 3'b0};
            default:                prod = 32'd0;
         endcase
         stored_size = (prod + 32'd1) & ~32'd1;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tiff_directory_builder_unit.sv @@
// Top level of the TIFF directory builder: controller plus datapath.
// Depends on tdb_pkg, tdb_ctrl and tdb_datapath.
// Add: accept, then match and write; a table-full result follows if the table
// is full and the id is new. Emit: header, then per entry a scan of every
// table slot and a pick, then a last scan that finds none and the trailer.
// Results are strobed for one cycle and cannot be stalled.
// Synchronous active-high reset empties the table and sets the offset to 8.
`default_nettype none

module tiff_directory_builder_unit #(
   parameter int MAX_TAGS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tdb_pkg::req_type req_data,
   output logic                  rsp_valid,
   output tdb_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [31:0]      csr_data
);

   tdb_pkg::ctrl_cmd_type  cmd;
   tdb_pkg::dp_status_type status;

   tdb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tdb_datapath #(.MAX_TAGS(MAX_TAGS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Register write is always taken
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

@@ rtl/core/tdb_ctrl.sv @@
// Controller state machine of the TIFF directory builder.
// Depends on tdb_pkg for the command and status structs.
`default_nettype none

module tdb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire tdb_pkg::dp_status_type status,
   output tdb_pkg::ctrl_cmd_type       cmd,
   output logic                        busy
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_HDR,
      S_SCAN,
      S_PICK
   } state_type;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = status.req_is_emit ? S_HDR : S_ADD;
            end
         end
         S_ADD:  state_in = S_IDLE;
         S_HDR:  state_in = S_SCAN;
         S_SCAN: begin
            if (status.scan_last) begin
               state_in = S_PICK;
            end
         end
         S_PICK: state_in = status.best_found ? S_SCAN : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command decode
   always_comb begin
      cmd        = '0;
      cmd.latch  = (state_ff == S_IDLE) && start;
      cmd.add    = (state_ff == S_ADD);
      cmd.header = (state_ff == S_HDR);
      cmd.scan   = (state_ff == S_SCAN);
      cmd.pick   = (state_ff == S_PICK);
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/tdb_datapath.sv @@
// Datapath of the TIFF directory builder: tag table, id match, sorted scan,
// offset arithmetic and the result register. Depends on tdb_pkg.
`default_nettype none

module tdb_datapath #(
   parameter int MAX_TAGS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tdb_pkg::req_type      req_data,
   input  wire tdb_pkg::ctrl_cmd_type cmd,
   input  wire logic                  csr_valid,
   input  wire logic [31:0]           csr_data,
   output tdb_pkg::dp_status_type     status,
   output logic                       rsp_valid,
   output tdb_pkg::rsp_type           rsp_data
);

   localparam int IDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAGS - 1);
   localparam logic [5:0] MAX_CNT = 6'(MAX_TAGS);

   // Tag table
   logic [MAX_TAGS-1:0] valid_ff;
   logic [15:0]         id_ff     [MAX_TAGS];
   logic [3:0]          type_ff   [MAX_TAGS];
   logic [27:0]         count_ff  [MAX_TAGS];
   logic [31:0]         inline_ff [MAX_TAGS];
   logic [5:0]          stored_ff;

   tdb_pkg::req_type req_ff;
   logic [31:0]      start_off_ff;

   // Scan state
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] best_ff;
   logic             best_valid_ff;
   logic [15:0]      prev_ff;
   logic             prev_valid_ff;
   logic [31:0]      offset_ff;
   logic [31:0]      data_total_ff;

   tdb_pkg::rsp_type rsp_ff;
   tdb_pkg::rsp_type rsp_in;
   logic             rsp_valid_ff;

   // Parallel id match
   logic             match;
   logic [IDX_W-1:0] match_idx;
   logic             full;
   logic [IDX_W-1:0] wr_idx;

   always_comb begin
      match     = 1'b0;
      match_idx = '0;
      for (int i = 0; i < MAX_TAGS; i++) begin
         if (!match && valid_ff[i] && id_ff[i] == req_ff.tag_id) begin
            match     = 1'b1;
            match_idx = IDX_W'(i);
         end
      end
   end

   assign full   = (stored_ff >= MAX_CNT);
   assign wr_idx = match ? match_idx : stored_ff[IDX_W-1:0];

   // Header bytes: count, entries, next-directory link
   logic [31:0] hdr_bytes;
   assign hdr_bytes = tdb_pkg::COUNT_BYTES + ({26'b0, stored_ff} << 3)
                      + ({26'b0, stored_ff} << 2) + tdb_pkg::LINK_BYTES;

   // Scan candidate
   logic        cand;
   assign cand = valid_ff[idx_ff]
                 && (!prev_valid_ff || id_ff[idx_ff] > prev_ff)
                 && (!best_valid_ff || id_ff[idx_ff] < id_ff[best_ff]);

   // Selected entry
   logic [31:0] sz;
   logic [31:0] val;
   assign sz = tdb_pkg::stored_size(count_ff[best_ff], type_ff[best_ff]);

   always_comb begin
      if (sz > 32'd4) begin
         val = offset_ff;
      end else if (sz == 32'd4) begin
         val = inline_ff[best_ff];
      end else if (sz == 32'd2) begin
         val = {16'b0, inline_ff[best_ff][15:0]};
      end else begin
         val = 32'd0;
      end
   end

   // Table storage, no reset on payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.add && (match || !full)) begin
         id_ff[wr_idx]     <= req_ff.tag_id;
         type_ff[wr_idx]   <= req_ff.tag_type;
         count_ff[wr_idx]  <= req_ff.value_count;
         inline_ff[wr_idx] <= req_ff.inline_value;
      end
   end

   // Control state: valid bits, tag count, config register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         stored_ff    <= '0;
         start_off_ff <= 32'd8;
      end else begin
         if (csr_valid) begin
            start_off_ff <= csr_data;
         end
         if (cmd.add && !match && !full) begin
            valid_ff[wr_idx] <= 1'b1;
            stored_ff        <= stored_ff + 6'd1;
         end
      end
   end

   // Sorted scan, one slot a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         if (cmd.header) begin
            idx_ff        <= '0;
            best_valid_ff <= 1'b0;
            prev_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
            if (cand) begin
               best_valid_ff <= 1'b1;
            end
         end else if (cmd.pick) begin
            idx_ff        <= '0;
            best_valid_ff <= 1'b0;
            if (best_valid_ff) begin
               prev_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && cand) begin
         best_ff <= idx_ff;
      end
      if (cmd.header) begin
         offset_ff     <= start_off_ff + hdr_bytes;
         data_total_ff <= 32'd0;
      end else if (cmd.pick && best_valid_ff) begin
         prev_ff <= id_ff[best_ff];
         if (sz > 32'd4) begin
            offset_ff     <= offset_ff + sz;
            data_total_ff <= data_total_ff + sz;
         end
      end
   end

   // Next result contents
   always_comb begin
      rsp_in             = '0;
      rsp_in.entry_total = stored_ff;
      if (cmd.add) begin
         rsp_in.result_kind = tdb_pkg::KIND_FULL;
      end else if (cmd.header) begin
         rsp_in.result_kind = tdb_pkg::KIND_HEADER;
      end else if (cmd.pick && best_valid_ff) begin
         rsp_in.result_kind  = tdb_pkg::KIND_ENTRY;
         rsp_in.out_tag_id   = id_ff[best_ff];
         rsp_in.out_tag_type = type_ff[best_ff];
         rsp_in.out_count    = count_ff[best_ff];
         rsp_in.value_field  = val;
      end else begin
         rsp_in.result_kind    = tdb_pkg::KIND_TRAILER;
         rsp_in.directory_size = (data_total_ff + hdr_bytes + 32'd3) & ~32'd3;
         rsp_in.last           = 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.add && !match && full) || cmd.header || cmd.pick;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign status.req_is_emit = (req_data.cmd == tdb_pkg::CMD_EMIT);
   assign status.scan_last   = (idx_ff == LAST_IDX);
   assign status.best_found  = best_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/tdb_checker.sv @@
// Port-level checks for the TIFF directory builder, bound to the top level.
// Depends on tdb_pkg.
`default_nettype none

module tdb_checker #(
   parameter int MAX_TAGS = 32
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire tdb_pkg::rsp_type rsp_data
);

   // An accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   // Trailer is the last result of a run
   a_trailer_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == tdb_pkg::KIND_TRAILER |-> rsp_data.last)
      else $error("trailer without last");

   // After the trailer the block is free again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("busy after final result");

   // Table full only when the table really is full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == tdb_pkg::KIND_FULL
      |-> rsp_data.entry_total == 6'(MAX_TAGS))
      else $error("table full with free slots");

endmodule

bind tiff_directory_builder_unit tdb_checker #(.MAX_TAGS(MAX_TAGS)) u_chk (.*);

`default_nettype wire

@@ verif/tdb_directory_checker.sv @@
`timescale 1ns / 1ps
// Checker for the TIFF directory builder: watches the request, result and
// register channels, predicts the result stream and compares it. Uses tdb_pkg.

module tdb_directory_checker #(
   parameter int MAX_TAGS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire tdb_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire tdb_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [31:0]      csr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    checked_results
);

   // Predicted table and register
   logic        tbl_used  [MAX_TAGS];
   logic [15:0] tbl_id    [MAX_TAGS];
   logic [3:0]  tbl_type  [MAX_TAGS];
   logic [27:0] tbl_count [MAX_TAGS];
   logic [31:0] tbl_bytes [MAX_TAGS];
   int          tag_total;
   logic [31:0] dir_offset;

   tdb_pkg::rsp_type expected_rsps[$];

   // Bytes per value of each field type; unknown types count as zero
   function automatic logic [31:0] bytes_per_value(input logic [3:0] t);
      case (t)
         4'd1, 4'd2, 4'd6, 4'd7: return 32'd1;
         4'd3, 4'd8:             return 32'd2;
         4'd4, 4'd9, 4'd11:      return 32'd4;
         4'd5, 4'd10, 4'd12:     return 32'd8;
         default:                return 32'd0;
      endcase
   endfunction

   function automatic tdb_pkg::rsp_type blank_rsp(input logic [1:0] kind);
      tdb_pkg::rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.entry_total = 6'(tag_total);
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Work out the results of one accepted request
   task automatic predict_request(input tdb_pkg::req_type r);
      int               slot;
      int               best;
      int               last_id;
      logic [31:0]      run_offset;
      logic [31:0]      data_total;
      logic [31:0]      sz;
      tdb_pkg::rsp_type e;
      begin
         if (r.cmd == tdb_pkg::CMD_ADD) begin
            slot = -1;
            for (int i = 0; i < MAX_TAGS; i++)
               if (slot < 0 && tbl_used[i] && tbl_id[i] == r.tag_id) slot = i;
            if (slot < 0) begin
               if (tag_total >= MAX_TAGS) begin
                  expected_rsps.push_back(blank_rsp(tdb_pkg::KIND_FULL));
                  return;
               end
               slot = tag_total;
               tbl_used[slot] = 1'b1;
               tag_total++;
            end
            tbl_id[slot]    = r.tag_id;
            tbl_type[slot]  = r.tag_type;
            tbl_count[slot] = r.value_count;
            tbl_bytes[slot] = r.inline_value;
         end else begin
            expected_rsps.push_back(blank_rsp(tdb_pkg::KIND_HEADER));
            data_total = '0;
            run_offset = dir_offset + tdb_pkg::COUNT_BYTES
                         + tdb_pkg::ENTRY_BYTES * 32'(tag_total) + tdb_pkg::LINK_BYTES;
            last_id = -1;
            // ascending id walk; ids in the table are unique
            forever begin
               best = -1;
               for (int i = 0; i < MAX_TAGS; i++)
                  if (tbl_used[i] && int'(tbl_id[i]) > last_id &&
                      (best < 0 || tbl_id[i] < tbl_id[best])) best = i;
               if (best < 0) break;
               last_id = int'(tbl_id[best]);
               sz = ((32'(tbl_count[best]) * bytes_per_value(tbl_type[best])) + 32'd1)
                    & ~32'd1;
               e = blank_rsp(tdb_pkg::KIND_ENTRY);
               e.out_tag_id   = tbl_id[best];
               e.out_tag_type = tbl_type[best];
               e.out_count    = tbl_count[best];
               if (sz > 32'd4) begin
                  e.value_field = run_offset;
                  run_offset += sz;
                  data_total += sz;
               end else if (sz == 32'd4) e.value_field = tbl_bytes[best];
               else if (sz == 32'd2) e.value_field = {16'd0, tbl_bytes[best][15:0]};
               else e.value_field = '0;
               expected_rsps.push_back(e);
            end
            e = blank_rsp(tdb_pkg::KIND_TRAILER);
            e.directory_size = (data_total + tdb_pkg::COUNT_BYTES
                                + 32'(tag_total) * tdb_pkg::ENTRY_BYTES
                                + tdb_pkg::LINK_BYTES + 32'd3) & ~32'd3;
            e.last = 1'b1;
            expected_rsps.push_back(e);
         end
      end
   endtask

   // Compare one strobed result with the oldest expectation
   task automatic check_result(input tdb_pkg::rsp_type got);
      tdb_pkg::rsp_type want;
      begin
         checked_results++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: result with nothing expected, kind %0d", $realtime,
                     got.result_kind);
            fail_count++;
            return;
         end
         want = expected_rsps.pop_front();
         if (got.result_kind != want.result_kind)
            report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
         if (got.entry_total != want.entry_total)
            report("entry_total", 32'(got.entry_total), 32'(want.entry_total));
         if (got.out_tag_id != want.out_tag_id)
            report("out_tag_id", 32'(got.out_tag_id), 32'(want.out_tag_id));
         if (got.out_tag_type != want.out_tag_type)
            report("out_tag_type", 32'(got.out_tag_type), 32'(want.out_tag_type));
         if (got.out_count != want.out_count)
            report("out_count", 32'(got.out_count), 32'(want.out_count));
         if (got.value_field != want.value_field)
            report("value_field", got.value_field, want.value_field);
         if (got.directory_size != want.directory_size)
            report("directory_size", got.directory_size, want.directory_size);
         if (got.last != want.last)
            report("last", 32'(got.last), 32'(want.last));
      end
   endtask

   // Sample every channel at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAGS; i++) tbl_used[i] = 1'b0;
         tag_total  = 0;
         dir_offset = 32'd8;
         expected_rsps.delete();
      end else begin
         if (rsp_valid) check_result(rsp_data);
         if (csr_valid && csr_ready) dir_offset = csr_data;
         if (start && !busy) predict_request(req_data);
      end
      pending = expected_rsps.size();
   end

   initial begin
      fail_count      = 0;
      pending         = 0;
      checked_results = 0;
   end

endmodule

@@ verif/tiff_directory_builder_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the TIFF directory builder: clock, reset, stimulus and
// verdict. Depends on tdb_pkg, the block and tdb_directory_checker.

module tiff_directory_builder_unit_test;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 80;
   localparam int RANDOM_ITEMS = 440;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   tdb_pkg::req_type req_data;
   logic             rsp_valid;
   tdb_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [31:0]      csr_data;

   int fail_count;
   int pending;
   int checked_results;
   int items_sent;
   int idle_pct;
   int quiet_cycles;
   logic [15:0] id_pool[40];

   tiff_directory_builder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   tdb_directory_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked_results (checked_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("tiff_directory_builder_unit_test failed");
         $finish;
      end
   end

   // One request transfer, with random idle cycles in front
   task automatic send_request(input tdb_pkg::req_type r);
      logic taken;
      begin
         while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
         start    <= 1'b1;
         req_data <= r;
         do begin
            @(negedge clock);
            taken = !busy;
            @(posedge clock);
         end while (!taken);
         items_sent++;
      end
   endtask

   task automatic send_add(input logic [15:0] id, input logic [3:0] t,
                           input logic [27:0] cnt, input logic [31:0] bytes);
      tdb_pkg::req_type r;
      r.cmd          = tdb_pkg::CMD_ADD;
      r.tag_id       = id;
      r.tag_type     = t;
      r.value_count  = cnt;
      r.inline_value = bytes;
      send_request(r);
   endtask

   task automatic send_emit();
      tdb_pkg::req_type r;
      r      = tdb_pkg::req_type'({$urandom, $urandom, $urandom});
      r.cmd  = tdb_pkg::CMD_EMIT;
      send_request(r);
   endtask

   // Let every expected result arrive and the block fall quiet
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_offset(input logic [31:0] v);
      logic taken;
      begin
         drain();
         csr_valid <= 1'b1;
         csr_data  <= v;
         do begin
            @(negedge clock);
            taken = csr_ready;
            @(posedge clock);
         end while (!taken);
         csr_valid <= 1'b0;
      end
   endtask

   // Random traffic: mostly adds from a small id pool so replacements
   // and the full table are reached, some emits, some fully random ids
   task automatic random_phase(input int n);
      int pick;
      logic [27:0] cnt;
      begin
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            cnt  = ($urandom_range(3) == 0) ? 28'($urandom) : 28'($urandom_range(5));
            if (pick < 15) send_emit();
            else if (pick < 25)
               send_add(16'($urandom), 4'($urandom), cnt, $urandom);
            else
               send_add(id_pool[$urandom_range(39)], 4'($urandom_range(15)), cnt,
                        $urandom);
         end
      end
   endtask

   initial begin
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      items_sent = 0;
      quiet_cycles = 0;
      idle_pct   = 0;
      foreach (id_pool[i]) id_pool[i] = 16'($urandom);
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty emit, field extremes, each value-field case
      send_emit();
      send_add(16'h0000, 4'd1, 28'd1, 32'hA5A5_5A5A);   // one byte, rounds to two
      send_add(16'hFFFF, 4'd4, 28'd1, 32'hDEAD_BEEF);   // exactly four bytes
      send_add(16'h1234, 4'd5, 28'd3, 32'hFFFF_FFFF);   // out of line
      send_add(16'h0100, 4'd1, 28'd0, 32'h1111_1111);   // zero size
      send_add(16'h0200, 4'd0, 28'd7, 32'h2222_2222);   // unknown type
      send_add(16'h0300, 4'd13, 28'h0FF_FFFF, 32'h3);
      send_add(16'h0400, 4'd15, 28'h0FF_FFFF, 32'h4);
      send_add(16'h0500, 4'd12, 28'h0FFF_FFFF, 32'h5);  // largest count at eight bytes per value
      send_add(16'h0600, 4'd3, 28'd1, 32'h0000_CAFE);
      send_add(16'h0700, 4'd2, 28'd5, 32'h7);
      send_add(16'h0800, 4'd11, 28'd2, 32'h8);
      send_emit();
      send_add(16'h1234, 4'd8, 28'd2, 32'h7654_3210);   // replace
      send_add(16'hFFFF, 4'd10, 28'd9, 32'h0);          // replace with large size
      send_emit();

      write_offset(32'h0000_0000);
      idle_pct = 38;
      random_phase(RANDOM_ITEMS / 3);
      write_offset(32'hFFFF_FFFF);
      idle_pct = 49;
      random_phase(RANDOM_ITEMS / 3);
      write_offset($urandom);
      idle_pct = 0;
      random_phase(RANDOM_ITEMS / 3);
      write_offset(32'd8);
      send_emit();

      drain();
      $display("%0d requests sent, %0d results checked; three idle profiles, five offsets",
               items_sent, checked_results);
      if (fail_count == 0)
         $display("tiff_directory_builder_unit_test passed");
      else
         $display("tiff_directory_builder_unit_test failed");
      $finish;
   end

endmodule

@@ tiff_directory_builder_unit.f @@
rtl/core/tdb_pkg.sv
rtl/core/tdb_ctrl.sv
rtl/core/tdb_datapath.sv
rtl/core/tiff_directory_builder_unit.sv
rtl/core/tdb_checker.sv
verif/tdb_directory_checker.sv
verif/tiff_directory_builder_unit_test.sv
